// File: src/bmhq_pkg.sv
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int BMHQ_DEPTH = 1024;

    localparam int KEY_W  = 16;
    localparam int TAG_W  = 8;
    localparam int PAY_W  = 16;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 11;

    // operation kinds
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        t_entry            entry;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

// File: src/bmhq_ram.sv
`timescale 1ns / 1ps

module bmhq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bmhq_core.sv
`timescale 1ns / 1ps

module bmhq_core
    import bmhq_pkg::*;
#(
    parameter int DEPTH = BMHQ_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_op,
    input  t_entry  i_entry,
    output logic    o_idle,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_take
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UP   = 4'd1;  // compare with parent, move hole up
    localparam logic [3:0] S_WCUR = 4'd2;  // drop moving entry at the root
    localparam logic [3:0] S_ROOT = 4'd3;  // root read back
    localparam logic [3:0] S_LAST = 4'd4;  // last entry read back
    localparam logic [3:0] S_DN   = 4'd5;  // fetch left child
    localparam logic [3:0] S_DNL  = 4'd6;  // left child compare
    localparam logic [3:0] S_DNR  = 4'd7;  // right child compare
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_pos, n_pos;
    t_entry            r_cur, n_cur;
    t_entry            r_best, n_best;
    logic [AW-1:0]     r_best_idx, n_best_idx;
    logic              r_have, n_have;
    logic [STAT_W-1:0] r_status, n_status;
    t_entry            r_out, n_out;

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    t_entry            wdata, rdata;

    logic [KEY_W-1:0]  cmp_a, cmp_b;
    logic              lt;
    logic [XW-1:0]     l_idx, r_idx;
    logic [AW-1:0]     par;
    logic              l_ok, r_ok;

    bmhq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // the one key comparator, shared by sift-up and sift-down
    assign cmp_a = (r_state == S_UP) ? r_cur.key : rdata.key;
    assign cmp_b = (r_state == S_UP) ? rdata.key : r_best.key;
    assign lt    = cmp_a < cmp_b;

    // slot 0 has a single child, slot 1
    assign l_idx = (r_pos == '0) ? XW'(1) : {r_pos, 1'b0};
    assign r_idx = {r_pos, 1'b1};
    assign l_ok  = l_idx < XW'(r_cnt);
    assign r_ok  = (r_pos != '0) && (r_idx < XW'(r_cnt));
    assign par   = r_pos >> 1;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_have     = r_have;
        n_status   = r_status;
        n_out      = r_out;
        we         = 1'b0;
        waddr      = r_pos;
        wdata      = r_cur;
        re         = 1'b0;
        raddr      = par;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = ST_DONE;
                    n_out    = '0;
                    if (i_op == OP_PUSH) begin
                        if (r_cnt == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_pos = AW'(r_cnt);
                            n_cnt = r_cnt + 1'b1;
                            n_cur = i_entry;
                            if (r_cnt == '0) begin
                                we      = 1'b1;
                                waddr   = '0;
                                wdata   = i_entry;
                                n_state = S_DONE;
                            end else begin
                                re      = 1'b1;
                                raddr   = AW'(r_cnt >> 1);
                                n_state = S_UP;
                            end
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            re      = 1'b1;
                            raddr   = '0;
                            n_cnt   = r_cnt - 1'b1;
                            n_state = S_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                we = 1'b1;
                if (lt) begin
                    // parent moves down into the hole
                    wdata = rdata;
                    n_pos = par;
                    if (par == '0) begin
                        n_state = S_WCUR;
                    end else begin
                        re    = 1'b1;
                        raddr = par >> 1;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WCUR: begin
                we      = 1'b1;
                n_state = S_DONE;
            end
            S_ROOT: begin
                n_out = rdata;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    re      = 1'b1;
                    raddr   = AW'(r_cnt);
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_cur   = rdata;
                n_pos   = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (l_ok) begin
                    re      = 1'b1;
                    raddr   = AW'(l_idx);
                    n_best  = r_cur;
                    n_state = S_DNL;
                end else begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DNL, S_DNR: begin
                if (r_state == S_DNL) begin
                    n_have     = lt;
                    n_best_idx = AW'(l_idx);
                end else if (lt) begin
                    n_have     = 1'b1;
                    n_best_idx = AW'(r_idx);
                end
                if (lt) begin
                    n_best = rdata;
                end
                if ((r_state == S_DNL) && r_ok) begin
                    re      = 1'b1;
                    raddr   = AW'(r_idx);
                    n_state = S_DNR;
                end else begin
                    we = 1'b1;
                    if (n_have) begin
                        // smaller child moves up into the hole
                        wdata   = n_best;
                        n_pos   = n_best_idx;
                        n_state = S_DN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_have     <= n_have;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.entry  = r_out;
    assign o_res.count  = CNT_W'(r_cnt);

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above depth");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("item started while busy");

    a_up_nonroot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UP |-> r_pos != '0)
        else $error("sift-up compare at root");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_FULL) |-> r_cnt == CW'(DEPTH))
        else $error("full flag with room left");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_EMPTY) |-> r_cnt == '0)
        else $error("empty flag with entries held");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_ROOT) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("pop did not drop the count");

endmodule

// File: src/binary_min_heap_queue.sv
`timescale 1ns / 1ps
// Flagged items and a push into an empty queue go straight to the result beat; other
// pushes first climb L levels (L <= log2(DEPTH)); a pop that empties the queue reads
// only the root; other pops also read the last entry and sift it down, level by level.
// One item at a time; at most one heap RAM read and one key compare per cycle.
// Reset: synchronous, active low; clears the count and handshake state. The heap RAM is
// not cleared: only slots below the count are ever read.

module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int DEPTH = BMHQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // key[15:0], tag[23:16], payload[39:24]
    input  logic [0:0]  s_axis_tuser,   // op[0]: 0 push, 1 pop
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_key[15:0], out_tag[23:16],
                                        // out_payload[39:24], count[50:40], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    logic    core_idle;
    logic    res_valid;
    logic    res_take;
    t_result res;
    t_entry  in_entry;

    logic        r_m_tvalid;
    logic [55:0] r_m_tdata;
    logic [1:0]  r_m_tuser;

    // a new item enters only when the sequencer is idle
    assign s_axis_tready = core_idle;

    assign in_entry.key     = s_axis_tdata[15:0];
    assign in_entry.tag     = s_axis_tdata[23:16];
    assign in_entry.payload = s_axis_tdata[39:24];

    bmhq_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid & core_idle),
        .i_op        (s_axis_tuser[0]),
        .i_entry     (in_entry),
        .o_idle      (core_idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // output register: the result moves here as soon as the slot is free, so the
    // sequencer can start the next item while this beat waits on the sink
    assign res_take = res_valid && (!r_m_tvalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_take) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_m_tdata <= {5'b0, res.count, res.entry.payload, res.entry.tag, res.entry.key};
            r_m_tuser <= res.status;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule
